// ----- design/rftb_pkg.sv -----
// package: constants, types and sequencer states of the ring finger table builder
package rftb_pkg;

    localparam int MACHINES  = 64;
    localparam int FINGERS   = 16;
    localparam int ID_BITS   = 16;
    localparam int SLOT_W    = $clog2(MACHINES);
    localparam int FIDX_W    = 4;
    localparam int FCOUNT_W  = 5;
    localparam int MCOUNT_W  = 7;
    localparam int RING_W    = 17;
    localparam int SUM_W     = 17;
    localparam int ALU_W     = RING_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = $clog2(SUM_W + 1);

    typedef logic [ID_BITS-1:0] id_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [FIDX_W-1:0]  fidx_t;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FINGER_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MACHINE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_FING,
        ST_DIV,
        ST_PREP,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

// ----- design/rftb_if.sv -----
// interfaces: request and response channels of the ring finger table builder
interface rftb_req_if;
    logic                valid;
    logic                ready;
    logic                mode;
    rftb_pkg::slot_t     slot;
    rftb_pkg::id_t       machine_id;

    modport source (output valid, output mode, output slot, output machine_id, input ready);
    modport sink   (input valid, input mode, input slot, input machine_id, output ready);
endinterface

interface rftb_rsp_if;
    logic                valid;
    logic                ready;
    rftb_pkg::fidx_t     finger_index;
    rftb_pkg::id_t       successor_id;
    logic                last;

    modport source (output valid, output finger_index, output successor_id, output last,
                    input ready);
    modport sink   (input valid, input finger_index, input successor_id, input last,
                     output ready);
endinterface

// ----- design/ring_finger_table_builder.sv -----
// top level: identifier table and finger table sequencer with one shared subtractor
//
// channel  | dir | payload                               | beat
// ---------+-----+---------------------------------------+------------------------------
// req      | in  | mode, slot, machine_id                | one load or one query
// rsp      | out | finger_index, successor_id, last      | one finger result
// cfg      | in  | cfg_we, cfg_index, cfg_data           | one register write
//
// a load beat is written straight into the table. a query first fetches its base id, then
// for each finger forms base + 2^i, reduces it by restoring remainder against ring_size
// (skipped when ring_size is zero), starts the table read, compares against up to
// machine_count table entries in slot order and sends one result beat per finger.
// the remainder steps and the table compares share one 18-bit subtractor, and the
// table is a 64-entry memory with one registered read port, one entry a cycle.
// reset sets the registers to finger_count 16, machine_count 1, ring_size 65536; the
// table holds no valid bits and needs no clearing pass.
// req.ready is high only between queries; a stalled result holds the sequencer.
module ring_finger_table_builder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rftb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rftb_pkg::RING_W-1:0]       cfg_data,
    rftb_req_if.sink                          req,
    rftb_rsp_if.source                        rsp
);
    import rftb_pkg::*;

    // configuration registers
    logic [FCOUNT_W-1:0] finger_count_reg;
    logic [MCOUNT_W-1:0] machine_count_reg;
    logic [RING_W-1:0]   ring_size_reg;

    // sequencer state
    state_t              state_reg, state_next;
    id_t                 base_reg, base_next;
    logic [SUM_W-1:0]    pow_reg, pow_next;
    fidx_t               fidx_reg, fidx_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [RING_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SUM_W-1:0]    target_reg, target_next;
    slot_t               j_reg, j_next;
    slot_t               cmp_reg, cmp_next;
    id_t                 first_reg, first_next;
    id_t                 succ_reg, succ_next;
    logic                last_reg, last_next;

    // table memory
    id_t                 id_table [MACHINES];
    id_t                 rd_data_reg;
    slot_t               rd_addr;
    logic                tbl_we;

    // shared subtractor
    logic [ALU_W-1:0]    alu_a, alu_b, alu_diff;
    logic                alu_borrow;

    // saturated counts, as last index
    fidx_t               flast;
    slot_t               mlast;
    logic [SUM_W-1:0]    sum;

    always_comb
    begin
        if (finger_count_reg == '0)
        begin
            flast = '0;
        end
        else if (finger_count_reg > FCOUNT_W'(FINGERS))
        begin
            flast = FIDX_W'(FINGERS - 1);
        end
        else
        begin
            flast = FIDX_W'(finger_count_reg - 1'b1);
        end

        if (machine_count_reg == '0)
        begin
            mlast = '0;
        end
        else if (machine_count_reg > MCOUNT_W'(MACHINES))
        begin
            mlast = SLOT_W'(MACHINES - 1);
        end
        else
        begin
            mlast = SLOT_W'(machine_count_reg - 1'b1);
        end
    end

    // register writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finger_count_reg  <= FCOUNT_W'(16);
            machine_count_reg <= MCOUNT_W'(1);
            ring_size_reg     <= RING_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FINGER_COUNT:  finger_count_reg  <= cfg_data[FCOUNT_W-1:0];
                CFG_MACHINE_COUNT: machine_count_reg <= cfg_data[MCOUNT_W-1:0];
                CFG_RING_SIZE:     ring_size_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // table: one write port, one registered read port
    assign tbl_we = (state_reg == ST_IDLE) && req.valid && (req.mode == MODE_LOAD);

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            id_table[req.slot] <= req.machine_id;
        end
        rd_data_reg <= id_table[rd_addr];
    end

    // subtractor operands: remainder step or table compare
    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            alu_a = {rem_reg, dvd_reg[SUM_W-1]};
            alu_b = {1'b0, ring_size_reg};
        end
        else
        begin
            alu_a = {{(ALU_W-ID_BITS){1'b0}}, rd_data_reg};
            alu_b = {{(ALU_W-SUM_W){1'b0}}, target_reg};
        end
    end

    assign alu_diff   = alu_a - alu_b;
    assign alu_borrow = alu_diff[ALU_W-1];
    assign sum        = {{(SUM_W-ID_BITS){1'b0}}, base_reg} + pow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        pow_reg    <= pow_next;
        fidx_reg   <= fidx_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        target_reg <= target_next;
        j_reg      <= j_next;
        cmp_reg    <= cmp_next;
        first_reg  <= first_next;
        succ_reg   <= succ_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        pow_next    = pow_reg;
        fidx_next   = fidx_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        target_next = target_reg;
        j_next      = j_reg;
        cmp_next    = cmp_reg;
        first_next  = first_reg;
        succ_next   = succ_reg;
        last_next   = last_reg;
        rd_addr     = j_reg;
        req.ready   = 1'b0;
        rsp.valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                // base id read starts right at the query beat
                rd_addr   = req.slot;
                if (req.valid && (req.mode == MODE_QUERY))
                begin
                    state_next = ST_BASE;
                end
            end

            ST_BASE:
            begin
                base_next  = rd_data_reg;
                pow_next   = SUM_W'(1);
                fidx_next  = '0;
                state_next = ST_FING;
            end

            ST_FING:
            begin
                // target before reduction; zero ring size means no reduction
                if (ring_size_reg == '0)
                begin
                    target_next = sum;
                    state_next  = ST_PREP;
                end
                else
                begin
                    dvd_next   = sum;
                    rem_next   = '0;
                    step_next  = STEP_W'(SUM_W);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // restoring remainder, one dividend bit a cycle
                rem_next  = alu_borrow ? alu_a[RING_W-1:0] : alu_diff[RING_W-1:0];
                dvd_next  = {dvd_reg[SUM_W-2:0], 1'b0};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    target_next = alu_borrow ? alu_a[SUM_W-1:0] : alu_diff[SUM_W-1:0];
                    state_next  = ST_PREP;
                end
            end

            ST_PREP:
            begin
                rd_addr    = '0;
                j_next     = SLOT_W'(1);
                cmp_next   = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                // rd_data_reg holds entry cmp_reg, entry j_reg is being read
                rd_addr  = j_reg;
                j_next   = j_reg + 1'b1;
                cmp_next = cmp_reg + 1'b1;
                if (cmp_reg == '0)
                begin
                    first_next = rd_data_reg;
                end
                last_next = (fidx_reg == flast);
                if (!alu_borrow)
                begin
                    succ_next  = rd_data_reg;
                    state_next = ST_OUT;
                end
                else if (cmp_reg == mlast)
                begin
                    // no entry at or above the target: wrap to slot 0
                    succ_next  = (cmp_reg == '0) ? rd_data_reg : first_reg;
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        fidx_next  = fidx_reg + 1'b1;
                        pow_next   = {pow_reg[SUM_W-2:0], 1'b0};
                        state_next = ST_FING;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.finger_index = fidx_reg;
    assign rsp.successor_id = succ_reg;
    assign rsp.last         = last_reg;

endmodule
